/* rtl/assert_macros.svh */
// concurrent assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/dq_pkg.sv */
package dq_pkg;

	localparam int ACT_W  = 3;
	localparam int STAT_W = 2;
	localparam int VAL_W  = 32;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
	localparam logic [ACT_W-1:0] ACT_PEEK_REAR  = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_SEEK
	} dq_state_t;

	// per-cell control: load the port word, or take a ring neighbor
	typedef struct packed {
		logic load;
		logic dn;
		logic up;
	} dq_cell_ctl_t;

endpackage

/* rtl/dq_req_if.sv */
interface dq_req_if import dq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic signed [VAL_W-1:0] push_value;

	modport source (output valid, action, push_value, input ready);
	modport sink   (input valid, action, push_value, output ready);
endinterface

/* rtl/dq_rsp_if.sv */
interface dq_rsp_if import dq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] out_value;
	logic [STAT_W-1:0]       status;
	logic                    is_empty;

	modport source (output valid, out_value, status, is_empty, input ready);
	modport sink   (input valid, out_value, status, is_empty, output ready);
endinterface

/* rtl/dq_cell.sv */
module dq_cell import dq_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  dq_cell_ctl_t          ctl,
	input  logic [WORD_WIDTH-1:0] load_word,
	input  logic [WORD_WIDTH-1:0] from_hi,
	input  logic [WORD_WIDTH-1:0] from_lo,
	output logic [WORD_WIDTH-1:0] word
);

	logic [WORD_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= load_word;
		end else if (ctl.dn) begin
			word_q <= from_hi;
		end else if (ctl.up) begin
			word_q <= from_lo;
		end
	end

	assign word = word_q;

endmodule

/* rtl/double_ended_queue.sv */
// channel | dir | fields                          | accepted when
// req     | in  | action, push_value              | req.valid && req.ready
// rsp     | out | out_value, status, is_empty     | rsp.valid && rsp.ready
//
// the ring of cells rotates one place a cycle while seeking; only cell 0 is read or written
// an item needs r = min(t, DEPTH - t) rotations, t the cell it touches (r = 0 on errors)
// its result is registered once the rotations are done and the result slot is free; the next
// request is taken only back in idle, so requests never overlap; unused codes rotate nothing
// reset clears head, count and control; the cell words stay undefined until written
// a request is taken while a result still waits, but completes only once that result is taken
`include "assert_macros.svh"

module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	dq_req_if.sink      req,
	dq_rsp_if.source    rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [AW-1:0] HALF = AW'(DEPTH / 2);
	localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);

	function automatic logic [WORD_WIDTH-1:0] to_word(input logic [VAL_W-1:0] v);
		logic [WORD_WIDTH-1:0] w;
		w = '0;
		for (int i = 0; i < WORD_WIDTH; i++) begin
			if (i < VAL_W) w[i] = v[i[4:0]];
		end
		return w;
	endfunction

	function automatic logic [VAL_W-1:0] from_word(input logic [WORD_WIDTH-1:0] w);
		logic [VAL_W-1:0] v;
		v = '0;
		for (int i = 0; i < WORD_WIDTH; i++) begin
			if (i < VAL_W) v[i[4:0]] = w[i];
		end
		return v;
	endfunction

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
		return (x == LAST) ? '0 : AW'(x + AW'(1));
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
		return (x == '0) ? LAST : AW'(x - AW'(1));
	endfunction

	dq_state_t             state_q, state_d;
	logic [ACT_W-1:0]      act_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [AW-1:0]         head_q, head_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [AW-1:0]         tgt_q, tgt_d;
	logic                  need_q, need_d;
	logic [STAT_W-1:0]     stat_q, stat_d;

	logic                  rsp_valid_q;
	logic [VAL_W-1:0]      rsp_value_q;
	logic [STAT_W-1:0]     rsp_stat_q;
	logic                  rsp_empty_q;

	logic                  accept, fin, slot_free, is_push;
	logic [CW-1:0]         fin_cnt;
	logic [CW:0]           sum_rear, sum_last;
	logic [AW-1:0]         at_rear, at_last;
	dq_cell_ctl_t          ring_ctl;
	logic [WORD_WIDTH-1:0] cell_word [DEPTH];

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign is_push   = (act_q == ACT_PUSH_FRONT) || (act_q == ACT_PUSH_REAR);

	// ring cells just past the rear and at the rear
	assign sum_rear = (CW + 1)'(head_q) + (CW + 1)'(cnt_q);
	assign sum_last = sum_rear - (CW + 1)'(1);
	assign at_rear  = (sum_rear >= DEPTH_X) ? AW'(sum_rear - DEPTH_X) : AW'(sum_rear);
	assign at_last  = (sum_last >= DEPTH_X) ? AW'(sum_last - DEPTH_X) : AW'(sum_last);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		cnt_d    = cnt_q;
		tgt_d    = tgt_q;
		need_d   = need_q;
		stat_d   = stat_q;
		ring_ctl = '0;
		fin      = 1'b0;
		fin_cnt  = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SEEK;
					need_d  = 1'b0;
					stat_d  = STAT_OK;
					tgt_d   = head_q;
					if (req.action inside {ACT_PUSH_FRONT, ACT_PUSH_REAR}) begin
						if (cnt_q == CW'(DEPTH)) begin
							stat_d = STAT_FULL;
						end else begin
							need_d = 1'b1;
							tgt_d  = (req.action == ACT_PUSH_FRONT) ? ring_dec(head_q) : at_rear;
						end
					end else if (req.action inside {ACT_POP_FRONT, ACT_POP_REAR,
							ACT_PEEK_FRONT, ACT_PEEK_REAR}) begin
						if (cnt_q == '0) begin
							stat_d = STAT_EMPTY;
						end else begin
							need_d = 1'b1;
							tgt_d  = (req.action inside {ACT_POP_FRONT, ACT_PEEK_FRONT})
								? head_q : at_last;
						end
					end
				end
			end
			S_SEEK: begin
				if (need_q && tgt_q != '0) begin
					// rotate the nearer way until the touched entry sits in cell 0
					if (tgt_q <= HALF) begin
						ring_ctl.dn = 1'b1;
						tgt_d       = ring_dec(tgt_q);
						head_d      = ring_dec(head_q);
					end else begin
						ring_ctl.up = 1'b1;
						tgt_d       = ring_inc(tgt_q);
						head_d      = ring_inc(head_q);
					end
				end else if (slot_free) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (need_q) begin
						case (act_q)
							ACT_PUSH_FRONT: begin
								ring_ctl.load = 1'b1;
								head_d        = '0;
								fin_cnt       = cnt_q + CW'(1);
							end
							ACT_PUSH_REAR: begin
								ring_ctl.load = 1'b1;
								fin_cnt       = cnt_q + CW'(1);
							end
							ACT_POP_FRONT: begin
								head_d  = ring_inc('0);
								fin_cnt = cnt_q - CW'(1);
							end
							ACT_POP_REAR: begin
								fin_cnt = cnt_q - CW'(1);
							end
							default: begin
							end
						endcase
					end
					cnt_d = fin_cnt;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			need_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			head_q <= head_d;
			cnt_q  <= cnt_d;
			need_q <= need_d;
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tgt_q  <= tgt_d;
		stat_q <= stat_d;
		if (accept) begin
			act_q  <= req.action;
			word_q <= to_word(req.push_value);
		end
		if (fin) begin
			rsp_value_q <= (need_q && !is_push) ? from_word(cell_word[0]) : '0;
			rsp_stat_q  <= stat_q;
			rsp_empty_q <= (fin_cnt == '0);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dq_cell_ctl_t cell_ctl;

		assign cell_ctl.load = (i == 0) ? ring_ctl.load : 1'b0;
		assign cell_ctl.dn   = ring_ctl.dn;
		assign cell_ctl.up   = ring_ctl.up;

		dq_cell #(
			.WORD_WIDTH(WORD_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.load_word(word_q),
			.from_hi  (cell_word[(i + 1) % DEPTH]),
			.from_lo  (cell_word[(i + DEPTH - 1) % DEPTH]),
			.word     (cell_word[i])
		);
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_value = rsp_value_q;
	assign rsp.status    = rsp_stat_q;
	assign rsp.is_empty  = rsp_empty_q;

	`ASSERT_PROP(a_rotate_keeps_count, clk, arst_n, (ring_ctl.dn || ring_ctl.up) |=> $stable(cnt_q), "count moved during rotation")
	`ASSERT_PROP(a_push_grows, clk, arst_n, (fin && need_q && is_push) |=> (cnt_q == $past(cnt_q) + CW'(1)), "accepted push did not grow the queue")
	`ASSERT_PROP(a_empty_flagged, clk, arst_n, (rsp.valid && rsp.status == STAT_EMPTY) |-> rsp.is_empty, "empty error on a queue that holds entries")
	`ASSERT_NEVER(a_over_depth, clk, arst_n, cnt_q > CW'(DEPTH), "count beyond depth")

endmodule
